// ===== src/aes128_key_schedule_unit_defines.svh =====
// Assertion macros for the AES-128 key schedule unit.
`ifndef AES128_KEY_SCHEDULE_UNIT_DEFINES_SVH
`define AES128_KEY_SCHEDULE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define AKSKD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("key schedule check failed");
// Next-cycle implication, disabled while reset is asserted
`define AKSKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("key schedule check failed");
`else
`define AKSKD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define AKSKD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/akskd_pkg.sv =====
package akskd_pkg;

	localparam int RoundsDefault = 10;
	localparam int RoundW        = 4;
	localparam int WordW         = 32;
	localparam int NumWords      = 4;
	localparam logic [7:0] RconFirst = 8'h01;
	localparam logic [7:0] RconPoly  = 8'h1B;

	typedef struct packed {
		logic [63:0] key_high;
		logic [63:0] key_low;
	} akskd_key_t;

	typedef struct packed {
		logic [RoundW-1:0] round_number;
		logic [63:0]       round_key_high;
		logic [63:0]       round_key_low;
		logic              last_key;
	} akskd_rkey_t;

	// Controls shared by every word cell
	typedef struct packed {
		logic load;
		logic step;
	} akskd_cell_ctrl_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EMIT
	} akskd_state_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	// Multiply by x in GF(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? RconPoly : 8'h00);
	endfunction

endpackage

// ===== src/akskd_sub_word.sv =====
// Key schedule core function: RotWord, SubWord, then round constant on top byte
module akskd_sub_word import akskd_pkg::*; (
	input  logic [WordW-1:0] last_word,
	input  logic [7:0]       rcon,
	output logic [WordW-1:0] temp_word
);

	logic [WordW-1:0] rot_word;
	logic [WordW-1:0] sub_word;

	assign rot_word = {last_word[23:0], last_word[31:24]};

	// Four S-box lookups, one per byte lane
	always_comb begin
		for (int b = 0; b < 4; b++) begin
			sub_word[b*8 +: 8] = SBOX[rot_word[b*8 +: 8]];
		end
	end

	assign temp_word = sub_word ^ {rcon, 24'h000000};

endmodule

// ===== src/akskd_word_cell.sv =====
// One word of the round key; its new value is its old value XOR the
// new value of the word to its left, which it hands on to its right.
module akskd_word_cell import akskd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  akskd_cell_ctrl_t ctrl,
	input  logic [WordW-1:0] load_word,
	input  logic [WordW-1:0] chain_in,
	output logic [WordW-1:0] word,
	output logic [WordW-1:0] chain_out
);

	logic [WordW-1:0] word_q;

	assign chain_out = word_q ^ chain_in;
	assign word      = word_q;

	// Payload register, loaded from the key or advanced one round
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (ctrl.load) begin
			word_q <= load_word;
		end else if (ctrl.step) begin
			word_q <= chain_out;
		end
	end

endmodule

// ===== src/aes128_key_schedule_unit.sv =====
// AES-128 key expansion: one cipher key in, round keys 0..ROUNDS out in order.
// Round key 0 is valid in the cycle after the key request is accepted.
// One round key per cycle while rkey_stall is low, ROUNDS+1 round keys per key (11 by
// default), the row of four word cells advancing one round per output request.
// A new key is taken in the cycle the last round key leaves.
// Reset (arst_n low, asynchronous) empties the unit; no output is pending.
`include "aes128_key_schedule_unit_defines.svh"

module aes128_key_schedule_unit import akskd_pkg::*; #(
	parameter int ROUNDS = RoundsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        key_valid,
	output logic        key_stall,
	input  akskd_key_t  key,
	output logic        rkey_valid,
	input  logic        rkey_stall,
	output akskd_rkey_t rkey
);

	localparam logic [RoundW-1:0] LastRound = RoundW'(ROUNDS);

	akskd_state_t      state_q;
	akskd_state_t      state_d;
	logic [RoundW-1:0] round_q;
	logic [7:0]        rcon_q;
	logic              key_fire;
	logic              rkey_fire;
	logic              last;
	akskd_cell_ctrl_t  cell_ctrl;

	logic [WordW-1:0] load_words [NumWords];
	logic [WordW-1:0] words      [NumWords];
	logic [WordW-1:0] chain      [NumWords+1];

	assign last      = (round_q == LastRound);
	assign key_fire  = key_valid && !key_stall;
	assign rkey_fire = rkey_valid && !rkey_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (key_valid) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (rkey_fire && last && !key_valid) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs; in ST_EMIT the output is always valid
	always_comb begin
		rkey_valid = 1'b0;
		key_stall  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rkey_valid = 1'b0;
				key_stall  = 1'b0;
			end
			ST_EMIT: begin
				rkey_valid = 1'b1;
				key_stall  = rkey_stall || !last;
			end
			default: begin
				rkey_valid = 1'b0;
				key_stall  = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Round number and round constant
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
			rcon_q  <= RconFirst;
		end else if (cell_ctrl.load) begin
			round_q <= '0;
			rcon_q  <= RconFirst;
		end else if (cell_ctrl.step) begin
			round_q <= round_q + RoundW'(1);
			rcon_q  <= xtime(rcon_q);
		end
	end

	assign cell_ctrl.load = key_fire;
	assign cell_ctrl.step = rkey_fire && !last;

	assign load_words[0] = key.key_high[63:32];
	assign load_words[1] = key.key_high[31:0];
	assign load_words[2] = key.key_low[63:32];
	assign load_words[3] = key.key_low[31:0];

	akskd_sub_word u_sub_word (
		.last_word (words[NumWords-1]),
		.rcon      (rcon_q),
		.temp_word (chain[0])
	);

	// Row of word cells, chained left to right
	for (genvar i = 0; i < NumWords; i++) begin : g_cell
		akskd_word_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl),
			.load_word (load_words[i]),
			.chain_in  (chain[i]),
			.word      (words[i]),
			.chain_out (chain[i+1])
		);
	end

	assign rkey.round_number   = round_q;
	assign rkey.round_key_high = {words[0], words[1]};
	assign rkey.round_key_low  = {words[2], words[3]};
	assign rkey.last_key       = last;

	// A new key always starts at round zero
	`AKSKD_ASSERT_NEXT(a_load_round0, clk, arst_n, key_fire, rkey_valid && round_q == '0)
	// A non-final request taken advances the round by one
	`AKSKD_ASSERT_NEXT(a_round_step, clk, arst_n, rkey_fire && !last,
		rkey_valid && round_q == $past(round_q) + RoundW'(1))
	// No new key while round keys other than the last remain
	`AKSKD_ASSERT_SAME(a_stall_busy, clk, arst_n, rkey_valid && !last, key_stall)
	// Round counter never passes the final round
	`AKSKD_ASSERT_SAME(a_round_range, clk, arst_n, rkey_valid, round_q <= LastRound)

endmodule

// ===== tb/aes128_key_schedule_unit_test.sv =====
`timescale 1ns / 100ps

module aes128_key_schedule_unit_test;
	import akskd_pkg::*;

	localparam int KeyRounds   = RoundsDefault;
	localparam int RandomKeys  = 93;
	localparam int StuckLimit  = 2000;
	localparam int TailCycles  = 24;
	localparam logic [7:0] AffineConst = 8'h63;

	// Directed key list; last_rk pins round key ROUNDS where it is a published value
	typedef struct packed {
		logic [63:0]  kh;
		logic [63:0]  kl;
		logic         pinned;
		logic [127:0] last_rk;
	} key_case_t;

	localparam key_case_t KeyCases [17] = '{
		'{64'h0000000000000000, 64'h0000000000000000, 1'b1,
			128'hb4ef5bcb3e92e21123e951cf6f8f188e},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 128'h0},
		'{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b1,
			128'hd014f9a8c9ee2589e13f0cc8b6630ca6},
		'{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b1,
			128'h13111d7fe3944a17f307a78b4d2b30c5},
		'{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 128'h0},
		'{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 128'h0},
		'{64'hffffffffffffffff, 64'h0000000000000000, 1'b0, 128'h0},
		'{64'h0000000000000000, 64'hffffffffffffffff, 1'b0, 128'h0},
		'{64'h8000000000000000, 64'h0000000000000001, 1'b0, 128'h0},
		'{64'h0000000000000001, 64'h8000000000000000, 1'b0, 128'h0},
		'{64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 128'h0},
		'{64'h00000000000000ff, 64'hff00000000000000, 1'b0, 128'h0},
		'{64'h0000000000000000, 64'h00000000000000ff, 1'b0, 128'h0},
		'{64'h0000000000000000, 64'h00000000ffffffff, 1'b0, 128'h0},
		// last word maps to zero through the S-box
		'{64'h0000000000000000, 64'h0000000052525252, 1'b0, 128'h0},
		// same key twice in a row: leftover state must not matter
		'{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b0, 128'h0},
		'{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b0, 128'h0}
	};

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        key_valid = 1'b0;
	logic        key_stall;
	akskd_key_t  key = '0;
	logic        rkey_valid;
	logic        rkey_stall = 1'b0;
	akskd_rkey_t rkey;

	bit           key_fire;
	bit           rkey_fire;
	bit           drive_pinned;
	logic [127:0] drive_last_rk;
	int           burst_left;
	int           fail_count;
	int           stuck_cycles;
	int           stall_hold;
	stall_mode_t  stall_mode;
	akskd_rkey_t  rkey_expect [$];

	aes128_key_schedule_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_valid  (key_valid),
		.key_stall  (key_stall),
		.key        (key),
		.rkey_valid (rkey_valid),
		.rkey_stall (rkey_stall),
		.rkey       (rkey)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// GF(2^8) doubling, reduction x^8+x^4+x^3+x+1
	function automatic logic [7:0] gf_double(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? RconPoly : 8'h00);
	endfunction

	function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 7; i >= 0; i--) begin
			acc = gf_double(acc);
			if (b[i])
				acc ^= a;
		end
		return acc;
	endfunction

	// S-box: inverse as a^254 (zero stays zero), then the affine map
	function automatic logic [7:0] sbox_of(input logic [7:0] a);
		logic [7:0] p2, p3, p4, p7, p8, p15, p30, p60, p67, p127, b;
		p2   = gf_times(a, a);
		p3   = gf_times(p2, a);
		p4   = gf_times(p2, p2);
		p7   = gf_times(p3, p4);
		p8   = gf_times(p4, p4);
		p15  = gf_times(p7, p8);
		p30  = gf_times(p15, p15);
		p60  = gf_times(p30, p30);
		p67  = gf_times(p7, p60);
		p127 = gf_times(p60, p67);
		b    = gf_times(p127, p127);
		return b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^
			{b[3:0], b[7:4]} ^ AffineConst;
	endfunction

	// Expand one cipher key and queue round keys 0..ROUNDS
	function automatic void expand_key(input akskd_key_t k, input bit pinned,
			input logic [127:0] last_rk);
		logic [31:0] w0, w1, w2, w3, t;
		logic [7:0]  rcon;
		akskd_rkey_t rk;
		{w0, w1} = k.key_high;
		{w2, w3} = k.key_low;
		rcon = RconFirst;
		for (int r = 0; r <= KeyRounds; r++) begin
			if (r > 0) begin
				t = {w3[23:0], w3[31:24]};
				t = {sbox_of(t[31:24]) ^ rcon, sbox_of(t[23:16]),
					sbox_of(t[15:8]), sbox_of(t[7:0])};
				w0 ^= t;
				w1 ^= w0;
				w2 ^= w1;
				w3 ^= w2;
				rcon = gf_double(rcon);
			end
			rk.round_number   = RoundW'(r);
			rk.round_key_high = {w0, w1};
			rk.round_key_low  = {w2, w3};
			rk.last_key       = (r == KeyRounds);
			if (pinned && r == KeyRounds)
				{rk.round_key_high, rk.round_key_low} = last_rk;
			rkey_expect.push_back(rk);
		end
	endfunction

	// Sample both channels mid-cycle, when everything has settled
	always @(negedge clk) begin
		akskd_rkey_t want;
		key_fire  = arst_n && key_valid && !key_stall;
		rkey_fire = arst_n && rkey_valid && !rkey_stall;
		if (key_fire)
			expand_key(key, drive_pinned, drive_last_rk);
		if (rkey_fire) begin
			if (rkey_expect.size() == 0) begin
				$error("round key %0d with none expected", rkey.round_number);
				fail_count++;
			end else begin
				want = rkey_expect.pop_front();
				if (rkey.round_number !== want.round_number) begin
					$error("round_number: expected %0d, got %0d",
						want.round_number, rkey.round_number);
					fail_count++;
				end
				if (rkey.round_key_high !== want.round_key_high) begin
					$error("round_key_high: expected %h, got %h",
						want.round_key_high, rkey.round_key_high);
					fail_count++;
				end
				if (rkey.round_key_low !== want.round_key_low) begin
					$error("round_key_low: expected %h, got %h",
						want.round_key_low, rkey.round_key_low);
					fail_count++;
				end
				if (rkey.last_key !== want.last_key) begin
					$error("last_key: expected %0b, got %0b", want.last_key, rkey.last_key);
					fail_count++;
				end
			end
		end
	end

	// Output backpressure: random modes held for random stretches
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_hold = $urandom_range(40, 160);
		end
		stall_hold--;
		case (stall_mode)
			STALL_NONE:  rkey_stall <= 1'b0;
			STALL_LIGHT: rkey_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: rkey_stall <= ($urandom_range(0, 3) != 0);
			default:     rkey_stall <= ((stall_hold % 5) < 2);
		endcase
	end

	// Watchdog on cycles with no request moving on either side
	always @(posedge clk) begin
		if (!arst_n || key_fire || rkey_fire)
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= StuckLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Present one key, with a random gap whenever a burst runs out
	task automatic send_key(input akskd_key_t k, input bit pinned, input logic [127:0] last_rk);
		if (burst_left == 0) begin
			key_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		key_valid     <= 1'b1;
		key           <= k;
		drive_pinned  = pinned;
		drive_last_rk = last_rk;
		do
			@(posedge clk);
		while (!key_fire);
	endtask

	// Hold off new keys until every queued round key is out
	task automatic drain_round_keys();
		key_valid  <= 1'b0;
		burst_left = 0;
		while (rkey_expect.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		akskd_key_t k;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed keys
		for (int i = 0; i < $size(KeyCases); i++) begin
			k.key_high = KeyCases[i].kh;
			k.key_low  = KeyCases[i].kl;
			send_key(k, KeyCases[i].pinned, KeyCases[i].last_rk);
		end
		drain_round_keys();

		// random keys, some biased sparse, dense or byte-repeated
		for (int i = 0; i < RandomKeys; i++) begin
			case ($urandom_range(0, 7))
				0: k = {$urandom, $urandom, $urandom, $urandom} &
					{$urandom, $urandom, $urandom, $urandom};
				1: k = {$urandom, $urandom, $urandom, $urandom} |
					{$urandom, $urandom, $urandom, $urandom};
				2: k = {16{8'($urandom)}};
				default: k = {$urandom, $urandom, $urandom, $urandom};
			endcase
			send_key(k, 1'b0, 128'h0);
			if (i % 40 == 39)
				drain_round_keys();
		end
		drain_round_keys();
		repeat (TailCycles) @(posedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/akskd_pkg.sv
src/akskd_sub_word.sv
src/akskd_word_cell.sv
src/aes128_key_schedule_unit.sv
tb/aes128_key_schedule_unit_test.sv
